// File: src/u2j_pkg.sv
// Shared types, character codes and helpers for the UTF-8 to JSON escape block.
`timescale 1ns / 1ps

package u2j_pkg;

  localparam int MaxChars = 8;

  // ASCII codes used by the escaper
  localparam logic [6:0] CH_NUL    = 7'h00;
  localparam logic [6:0] CH_QUOTE  = 7'h22;
  localparam logic [6:0] CH_BSLASH = 7'h5C;
  localparam logic [6:0] CH_U      = 7'h75;
  localparam logic [6:0] CH_B      = 7'h62;
  localparam logic [6:0] CH_F      = 7'h66;
  localparam logic [6:0] CH_T      = 7'h74;
  localparam logic [6:0] CH_N      = 7'h6E;
  localparam logic [6:0] CH_R      = 7'h72;

  // Byte values that have a two-character escape
  localparam logic [7:0] BYTE_QUOTE  = 8'h22;
  localparam logic [7:0] BYTE_BSLASH = 8'h5C;
  localparam logic [7:0] BYTE_BS     = 8'h08;
  localparam logic [7:0] BYTE_FF     = 8'h0C;
  localparam logic [7:0] BYTE_TAB    = 8'h09;
  localparam logic [7:0] BYTE_LF     = 8'h0A;
  localparam logic [7:0] BYTE_CR     = 8'h0D;

  localparam logic [7:0] LEAD_MIN = 8'hC0;
  localparam logic [7:0] LEAD_MAX = 8'hF4;

  // Characters produced by one input byte, oldest in entry 0
  typedef struct packed {
    logic [MaxChars-1:0][6:0] chars;
    logic [3:0]               count;   // 0..8
    logic                     last;    // byte closed the string
    logic                     bad;     // error result
  } burst_t;

  function automatic logic [6:0] hex_char(input logic [3:0] nib);
    hex_char = (nib < 4'd10) ? (7'h30 + {3'b000, nib}) : (7'h57 + {3'b000, nib});
  endfunction

endpackage

// File: src/u2j_decode.sv
// Byte decoder: sequence state and expansion of one byte into its escaped characters.
`timescale 1ns / 1ps

module u2j_decode (
  input  logic            clk,
  input  logic            rst,
  input  logic            advance,
  input  logic            escape_en,
  input  logic [7:0]      in_byte,
  input  logic            in_last,
  output u2j_pkg::burst_t burst
);

  logic [20:0] pending_code, pending_code_next;
  logic [1:0]  bytes_to_come, bytes_to_come_next;
  logic        error_seen, error_seen_next;

  logic        emit_uni, emit_ascii;
  logic [20:0] uni_code;
  logic [23:0] aligned;
  logic [2:0]  digits;
  logic [6:0]  esc;

  always_comb begin
    pending_code_next  = pending_code;
    bytes_to_come_next = bytes_to_come;
    error_seen_next    = error_seen;
    emit_uni           = 1'b0;
    emit_ascii         = 1'b0;
    if (error_seen) begin
      // swallow bytes until the end of the string
    end else if (bytes_to_come != 2'd0) begin
      pending_code_next  = {pending_code[14:0], in_byte[5:0]};
      bytes_to_come_next = bytes_to_come - 2'd1;
      emit_uni           = (bytes_to_come == 2'd1);
    end else if (in_byte[7]) begin
      if (in_byte >= u2j_pkg::LEAD_MIN && in_byte <= u2j_pkg::LEAD_MAX) begin
        priority if (in_byte[7:4] == 4'hF) begin
          bytes_to_come_next = 2'd3;
          pending_code_next  = {17'd0, in_byte[3:0]};
        end else if (in_byte[7:5] == 3'b111) begin
          bytes_to_come_next = 2'd2;
          pending_code_next  = {17'd0, in_byte[3:0]};
        end else begin
          bytes_to_come_next = 2'd1;
          pending_code_next  = {16'd0, in_byte[4:0]};
        end
      end else begin
        error_seen_next = 1'b1;
      end
    end else begin
      emit_ascii = 1'b1;
    end
  end

  // \u form: four to six digits, most significant first
  always_comb begin
    uni_code = emit_ascii ? {13'd0, in_byte} : pending_code_next;
    if (uni_code[20])                 digits = 3'd6;
    else if (uni_code[19:16] != 4'd0) digits = 3'd5;
    else                              digits = 3'd4;
    aligned = {3'b000, uni_code} << (5'd4 * (5'd6 - {2'b00, digits}));
  end

  always_comb begin
    unique case (in_byte)
      u2j_pkg::BYTE_QUOTE:  esc = u2j_pkg::CH_QUOTE;
      u2j_pkg::BYTE_BSLASH: esc = u2j_pkg::CH_BSLASH;
      u2j_pkg::BYTE_BS:     esc = u2j_pkg::CH_B;
      u2j_pkg::BYTE_FF:     esc = u2j_pkg::CH_F;
      u2j_pkg::BYTE_TAB:    esc = u2j_pkg::CH_T;
      u2j_pkg::BYTE_LF:     esc = u2j_pkg::CH_N;
      u2j_pkg::BYTE_CR:     esc = u2j_pkg::CH_R;
      default:              esc = u2j_pkg::CH_NUL;
    endcase
  end

  always_comb begin
    burst       = '0;
    burst.last  = in_last;
    if (in_last && (error_seen_next || bytes_to_come_next != 2'd0)) begin
      burst.chars[0] = u2j_pkg::CH_NUL;
      burst.count    = 4'd1;
      burst.bad      = 1'b1;
    end else if (emit_ascii &&
                 (!escape_en || (esc == u2j_pkg::CH_NUL && in_byte[6:5] != 2'b00))) begin
      burst.chars[0] = in_byte[6:0];
      burst.count    = 4'd1;
    end else if (emit_ascii && esc != u2j_pkg::CH_NUL) begin
      burst.chars[0] = u2j_pkg::CH_BSLASH;
      burst.chars[1] = esc;
      burst.count    = 4'd2;
    end else if (emit_ascii || emit_uni) begin
      burst.chars[0] = u2j_pkg::CH_BSLASH;
      burst.chars[1] = u2j_pkg::CH_U;
      for (int k = 0; k < 6; k++) begin
        burst.chars[k+2] = u2j_pkg::hex_char(aligned[23-4*k -: 4]);
      end
      burst.count = 4'd2 + {1'b0, digits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_code  <= '0;
      bytes_to_come <= '0;
      error_seen    <= 1'b0;
    end else if (advance) begin
      if (in_last) begin
        pending_code  <= '0;
        bytes_to_come <= '0;
        error_seen    <= 1'b0;
      end else begin
        pending_code  <= pending_code_next;
        bytes_to_come <= bytes_to_come_next;
        error_seen    <= error_seen_next;
      end
    end
  end

endmodule

// File: src/u2j_serializer.sv
// Result register: holds one byte's characters and shifts them out one per item.
`timescale 1ns / 1ps

module u2j_serializer (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  u2j_pkg::burst_t burst,
  output logic            free,
  output logic            valid,
  input  logic            take,
  output logic [6:0]      out_char,
  output logic            run_last,
  output logic            string_end,
  output logic            bad_string
);

  logic [u2j_pkg::MaxChars-1:0][6:0] chars;
  logic [3:0] remain;
  logic       last;
  logic       bad;
  logic       final_char;

  assign final_char = (remain == 4'd1);
  assign free       = !valid || (take && final_char);

  assign out_char   = chars[0];
  assign run_last   = final_char;
  assign string_end = final_char && last;
  assign bad_string = bad;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= 1'b0;
      remain <= '0;
    end else if (load) begin
      valid  <= (burst.count != 4'd0);
      remain <= burst.count;
    end else if (valid && take) begin
      valid  <= !final_char;
      remain <= remain - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      chars <= burst.chars;
      last  <= burst.last;
      bad   <= burst.bad;
    end else if (valid && take) begin
      chars <= {7'd0, chars[u2j_pkg::MaxChars-1:1]};
    end
  end

endmodule

// File: src/utf8_to_json_escape_core.sv
// Top level of the UTF-8 to JSON string escaper.
//
// Usage:
//   s_* : input stream, one UTF-8 byte per item in s_tdata, s_tlast on the
//         final byte of a string.
//   m_* : output stream, one ASCII character per item in m_tdata[6:0];
//         m_tlast marks the last character produced by one input byte,
//         m_tuser[0] the final character of the string, m_tuser[1] the
//         single error item of a bad string (character code 0).
//   cfg_*: escape_en register, written when cfg_valid and cfg_ready are
//         high; cfg_ready is always high. Write only while the block is idle.
// Timing: a byte is held in an input register, decoded combinationally into a
//   result register, and its characters leave one per cycle while m_tready
//   is high. The first character is on m_* once the byte has moved from the
//   input register into the result register. A byte makes 0 to 8 characters;
//   the next byte waits in the input register until the last of them is taken,
//   so the one-character output port sets the throughput; plain text runs at
//   one byte per cycle while m_tready is high.
// Reset: sequence state cleared, escape_en set to 1, both registers empty.
// Stall: while m_tready is low the result register holds, the input register
//   fills, and then s_tready drops; nothing is lost.
`timescale 1ns / 1ps

module utf8_to_json_escape_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       s_tlast,   // in_last
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [6:0] out_char, [7] zero
  output logic       m_tlast,   // run_last
  output logic [1:0] m_tuser,   // [0] string_end, [1] bad_string
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data   // escape_en
);

  logic            escape_en;
  logic            in_valid;
  logic [7:0]      in_byte;
  logic            in_last;
  logic            load;
  logic            ser_free;
  u2j_pkg::burst_t burst;
  logic [6:0]      out_char;
  logic            run_last, string_end, bad_string;

  assign cfg_ready = 1'b1;

  // Input register; it moves into the result register whenever that frees up
  assign load     = in_valid && ser_free;
  assign s_tready = !in_valid || load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (load) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_en <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      escape_en <= cfg_data;
    end
  end

  u2j_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .advance   (load),
    .escape_en (escape_en),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .burst     (burst)
  );

  u2j_serializer u_serializer (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .burst      (burst),
    .free       (ser_free),
    .valid      (m_tvalid),
    .take       (m_tready),
    .out_char   (out_char),
    .run_last   (run_last),
    .string_end (string_end),
    .bad_string (bad_string)
  );

  assign m_tdata = {1'b0, out_char};
  assign m_tlast = run_last;
  assign m_tuser = {bad_string, string_end};

  // An error item is always the last character of its byte and the final item of its string
  a_bad_closes: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && bad_string |-> run_last && string_end)
    else $error("error item does not close the string");

  // String end only on the last character of a byte
  a_end_on_run_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && string_end |-> run_last)
    else $error("string end before last character of byte");

  // A held byte stays until it is decoded
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !load |=> in_valid && $stable(in_byte) && $stable(in_last))
    else $error("input register lost a byte");

  // Escape mode comes out of reset enabled
  a_reset_escape: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> escape_en)
    else $error("escape mode not set after reset");

endmodule

// File: tb/u2j_escape_checker.sv
// Watches the escaper's streams, predicts each output character and checks it.
`timescale 1ns / 1ps

module u2j_escape_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  input  logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       s_tlast,   // in_last
  input  logic       m_tvalid,
  input  logic       m_tready,
  input  logic [7:0] m_tdata,   // [6:0] out_char, [7] zero
  input  logic       m_tlast,   // run_last
  input  logic [1:0] m_tuser,   // [0] string_end, [1] bad_string
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic       cfg_data,  // escape_en
  output int         fail_count,
  output int         expected_left
);

  typedef struct packed {
    logic [6:0] ch;
    logic       run_last;
    logic       str_end;
    logic       bad;
  } char_item_t;

  char_item_t  expected_chars[$];
  logic [6:0]  burst[$];          // characters of the byte being decoded

  // Shadow copy of the block's sequence state and register
  logic        esc_on;
  logic [20:0] code_acc;
  logic [1:0]  cont_left;
  logic        bad_seen;

  function automatic logic [6:0] hex_digit(input logic [3:0] v);
    if (v < 4'd10) return 7'h30 + {3'b000, v};
    return 7'h61 + {3'b000, v} - 7'd10;
  endfunction

  // \u plus four to six lowercase hex digits
  task add_code_point(input logic [20:0] code);
    int digits;
    int k;
    digits = 4;
    while (digits < 6 && (code >> (4 * digits)) != 21'd0) digits++;
    burst.push_back(u2j_pkg::CH_BSLASH);
    burst.push_back(u2j_pkg::CH_U);
    for (k = digits - 1; k >= 0; k--) burst.push_back(hex_digit(code[4*k +: 4]));
  endtask

  task add_ascii(input logic [7:0] b);
    logic [6:0] esc;
    esc = u2j_pkg::CH_NUL;
    if (!esc_on) begin
      burst.push_back(b[6:0]);
      return;
    end
    case (b)
      u2j_pkg::BYTE_QUOTE:  esc = u2j_pkg::CH_QUOTE;
      u2j_pkg::BYTE_BSLASH: esc = u2j_pkg::CH_BSLASH;
      u2j_pkg::BYTE_BS:     esc = u2j_pkg::CH_B;
      u2j_pkg::BYTE_FF:     esc = u2j_pkg::CH_F;
      u2j_pkg::BYTE_TAB:    esc = u2j_pkg::CH_T;
      u2j_pkg::BYTE_LF:     esc = u2j_pkg::CH_N;
      u2j_pkg::BYTE_CR:     esc = u2j_pkg::CH_R;
      default:              esc = u2j_pkg::CH_NUL;
    endcase
    if (esc != u2j_pkg::CH_NUL) begin
      burst.push_back(u2j_pkg::CH_BSLASH);
      burst.push_back(esc);
    end else if (b < 8'd32) begin
      add_code_point({13'd0, b});
    end else begin
      burst.push_back(b[6:0]);
    end
  endtask

  // Expected output characters for one accepted input byte
  task decode_byte(input logic [7:0] b, input logic fin);
    char_item_t item;
    int k;
    burst.delete();
    if (bad_seen) begin
      // swallowed until the final byte
    end else if (cont_left != 2'd0) begin
      code_acc = {code_acc[14:0], b[5:0]};
      cont_left = cont_left - 2'd1;
      if (cont_left == 2'd0) add_code_point(code_acc);
    end else if (b[7]) begin
      if (b >= u2j_pkg::LEAD_MIN && b <= u2j_pkg::LEAD_MAX) begin
        if (b[7:4] == 4'hF) begin
          cont_left = 2'd3;
          code_acc = {17'd0, b[3:0]};
        end else if (b[7:5] == 3'b111) begin
          cont_left = 2'd2;
          code_acc = {16'd0, b[4:0]};
        end else begin
          cont_left = 2'd1;
          code_acc = {15'd0, b[5:0]};
        end
      end else begin
        bad_seen = 1'b1;
      end
    end else begin
      add_ascii(b);
    end

    if (fin && (bad_seen || cont_left != 2'd0)) begin
      item = '{ch: u2j_pkg::CH_NUL, run_last: 1'b1, str_end: 1'b1, bad: 1'b1};
      expected_chars.push_back(item);
    end else begin
      for (k = 0; k < burst.size(); k++) begin
        item.ch       = burst[k];
        item.run_last = (k == burst.size() - 1);
        item.str_end  = (k == burst.size() - 1) && fin;
        item.bad      = 1'b0;
        expected_chars.push_back(item);
      end
    end

    if (fin) begin
      code_acc  = '0;
      cont_left = '0;
      bad_seen  = 1'b0;
    end
  endtask

  task check_char();
    char_item_t want;
    if (expected_chars.size() == 0) begin
      if (fail_count < 10)
        $display("%0t: unexpected output item data %h tlast %b tuser %b",
                 $realtime, m_tdata, m_tlast, m_tuser);
      fail_count++;
      return;
    end
    want = expected_chars.pop_front();
    if (m_tdata != {1'b0, want.ch} || m_tlast != want.run_last ||
        m_tuser[0] != want.str_end || m_tuser[1] != want.bad) begin
      if (fail_count < 10)
        $display("%0t: want ch %h last %b end %b bad %b, got %h tlast %b tuser %b",
                 $realtime, want.ch, want.run_last, want.str_end, want.bad,
                 m_tdata, m_tlast, m_tuser);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      esc_on     = 1'b1;
      code_acc   = '0;
      cont_left  = '0;
      bad_seen   = 1'b0;
      fail_count = 0;
      expected_chars.delete();
    end else begin
      if (cfg_valid && cfg_ready) esc_on = cfg_data;
      if (s_tvalid && s_tready) decode_byte(s_tdata, s_tlast);
      if (m_tvalid && m_tready) check_char();
    end
    expected_left = expected_chars.size();
  end

endmodule

// File: tb/utf8_to_json_escape_core_test.sv
// Stimulus and verdict for the UTF-8 to JSON escaper; checking lives in the checker.
`timescale 1ns / 1ps

module utf8_to_json_escape_core_test;

  logic       clk = 1'b0;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;    // [7:0] in_byte
  logic       s_tlast;    // in_last
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;    // [6:0] out_char, [7] zero
  logic       m_tlast;    // run_last
  logic [1:0] m_tuser;    // [0] string_end, [1] bad_string
  logic       cfg_valid;
  logic       cfg_ready;
  logic       cfg_data;   // escape_en

  int fail_count;
  int expected_left;

  // Percent chance per cycle that the sender holds off / the sink stalls
  int idle_pct  = 0;
  int stall_pct = 0;
  int bytes_sent;

  logic [7:0] str_buf[$];   // bytes of the string being built

  utf8_to_json_escape_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  u2j_escape_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tlast       (s_tlast),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tlast       (m_tlast),
    .m_tuser       (m_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .expected_left (expected_left)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Sink side: random backpressure, updated on the falling edge
  always @(negedge clk) begin
    m_tready = ($urandom_range(99) >= stall_pct);
  end

  // Hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  // One input item. Called at a falling edge, returns at the falling edge
  // after the handshake; tvalid stays high so back-to-back bytes need no gap.
  task put_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = b;
    s_tlast  = fin;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    bytes_sent++;
  endtask

  // Wait for the output to drain, then give any quiet byte time to clear
  // the decode stage (a byte waits in the input register before the result register).
  task wait_idle();
    s_tvalid = 1'b0;
    while (expected_left != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task write_escape(input logic v);
    cfg_valid = 1'b1;
    cfg_data  = v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // ASCII with a bias toward the bytes that have short escapes
  function automatic logic [7:0] rand_ascii();
    logic [7:0] shorts[7];
    shorts = '{u2j_pkg::BYTE_QUOTE, u2j_pkg::BYTE_BSLASH, u2j_pkg::BYTE_BS,
               u2j_pkg::BYTE_FF, u2j_pkg::BYTE_TAB, u2j_pkg::BYTE_LF,
               u2j_pkg::BYTE_CR};
    case ($urandom_range(3))
      0:       return shorts[$urandom_range(6)];
      1:       return 8'($urandom_range(31));
      default: return 8'($urandom_range(127));
    endcase
  endfunction

  // Lead byte plus continuations; cut != 0 leaves the sequence unfinished
  task add_sequence(input bit cut);
    int conts;
    int keep;
    int k;
    conts = $urandom_range(1, 3);
    case (conts)
      1:       str_buf.push_back(8'($urandom_range(8'hDF, 8'hC0)));
      2:       str_buf.push_back(8'($urandom_range(8'hEF, 8'hE0)));
      default: str_buf.push_back(8'($urandom_range(8'hF4, 8'hF0)));
    endcase
    keep = cut ? $urandom_range(0, conts - 1) : conts;
    for (k = 0; k < keep; k++) begin
      // continuation bits are never checked, so now and then any byte at all
      if ($urandom_range(99) < 85) str_buf.push_back({2'b10, 6'($urandom_range(63))});
      else str_buf.push_back(8'($urandom_range(255)));
    end
  endtask

  // Random string: mostly well formed, some invalid leads and cut sequences
  task send_string();
    int units;
    int kind;
    int k;
    str_buf.delete();
    units = $urandom_range(1, 4);
    for (k = 0; k < units; k++) begin
      kind = $urandom_range(99);
      if (kind < 50) begin
        str_buf.push_back(rand_ascii());
      end else if (kind < 85) begin
        add_sequence(1'b0);
      end else if (kind < 92) begin
        if ($urandom_range(1)) str_buf.push_back(8'($urandom_range(8'hBF, 8'h80)));
        else str_buf.push_back(8'($urandom_range(8'hFF, 8'hF5)));
      end else begin
        add_sequence(k == units - 1);
      end
    end
    for (k = 0; k < str_buf.size(); k++) put_byte(str_buf[k], k == str_buf.size() - 1);
  endtask

  initial begin
    int phase;
    int start;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tlast   = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = 1'b0;
    bytes_sent = 0;
    repeat (6) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // Directed, full escape on from reset: NUL as \u0000, every short escape, DEL
    put_byte(8'h00, 1'b0);
    put_byte(u2j_pkg::BYTE_QUOTE, 1'b0);
    put_byte(u2j_pkg::BYTE_BSLASH, 1'b0);
    put_byte(u2j_pkg::BYTE_BS, 1'b0);
    put_byte(u2j_pkg::BYTE_FF, 1'b0);
    put_byte(u2j_pkg::BYTE_TAB, 1'b0);
    put_byte(u2j_pkg::BYTE_LF, 1'b0);
    put_byte(u2j_pkg::BYTE_CR, 1'b0);
    put_byte(8'h7F, 1'b1);
    // two-byte lead whose continuation is a plain ASCII byte
    put_byte(8'hC3, 1'b0);
    put_byte(8'h41, 1'b1);
    // widest code point: eight output characters
    put_byte(8'hF4, 1'b0);
    put_byte(8'hBF, 1'b0);
    put_byte(8'hBF, 1'b0);
    put_byte(8'hBF, 1'b1);
    put_byte(8'hE2, 1'b0);
    put_byte(8'h82, 1'b0);
    put_byte(8'hAC, 1'b1);
    // invalid lead, then a byte that must be swallowed
    put_byte(8'h80, 1'b0);
    put_byte(8'h41, 1'b1);
    // sequence cut off by the final byte
    put_byte(8'hE2, 1'b0);
    put_byte(8'h82, 1'b1);
    // highest invalid lead as a one-byte string
    put_byte(8'hFF, 1'b1);

    // Plain mode: control bytes and quote pass through untouched
    wait_idle();
    write_escape(1'b0);
    put_byte(8'h00, 1'b0);
    put_byte(u2j_pkg::BYTE_QUOTE, 1'b0);
    put_byte(u2j_pkg::BYTE_LF, 1'b0);
    put_byte(8'h7F, 1'b1);

    // Random phases: no idling, slow sender, slow sink, both a little
    for (phase = 0; phase < 4; phase++) begin
      wait_idle();
      write_escape(phase[0] == 1'b0);
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 60; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 60; end
        default: begin idle_pct = 20; stall_pct = 20; end
      endcase
      start = bytes_sent;
      while (bytes_sent - start < 18) send_string();
    end

    // Drain and let any stray output show up before the verdict
    s_tvalid = 1'b0;
    while (expected_left != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0 && expected_left == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
